FILE: sv/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg: shared definitions for the inode reference table
// Widths, status codes, register indexes and the address result bundle.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int TABLE_SLOTS_DEF      = 32;
  localparam int INODE_BYTES_DEF      = 32;
  localparam int DISK_BLOCK_BYTES_DEF = 1024;

  localparam int NUM_W  = 16;
  localparam int CNT_W  = 8;
  localparam int SLOT_W = 5;
  localparam int OFF_W  = 10;
  localparam int BLK_W  = 16;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [NUM_W-1:0] AREA_BASE = 16'd2;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_HIT      = 3'd0;
  localparam status_t ST_FETCH    = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_UNUSED   = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  localparam logic [IDX_W-1:0] REG_IMAP = 8'd0;
  localparam logic [IDX_W-1:0] REG_ZMAP = 8'd1;

  // result of the address unit
  typedef struct packed {
    logic             done;
    logic [BLK_W-1:0] block_q;
    logic [OFF_W-1:0] offset;
  } loc_res_t;

endpackage

FILE: sv/irt_ram.sv
// ----------------------------------------------------------------------------
// irt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module irt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/irt_locate.sv
// ----------------------------------------------------------------------------
// irt_locate: inode number to disk block and byte offset
// One registered multiply; block and offset are the high and low parts of it.
// ----------------------------------------------------------------------------
module irt_locate
  import irt_pkg::*;
#(
  parameter int INODE_BYTES      = INODE_BYTES_DEF,
  parameter int DISK_BLOCK_BYTES = DISK_BLOCK_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] number,
  output loc_res_t         res
);

  localparam int BW = NUM_W + $clog2(INODE_BYTES);
  localparam int RW = $clog2(DISK_BLOCK_BYTES);

  logic [BW-1:0]    prod;
  logic             done;
  logic [NUM_W-1:0] idx;

  assign idx = number - 16'd1;

  // stays set once the first address is in
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (start) begin
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= BW'(idx * INODE_BYTES);
    end
  end

  // block size is a power of two: quotient is a shift, remainder a mask
  assign res.done    = done;
  assign res.block_q = BLK_W'(prod >> RW);
  assign res.offset  = OFF_W'(prod[RW-1:0]);

endmodule

FILE: sv/inode_reference_table.sv
// ----------------------------------------------------------------------------
// inode_reference_table: reference-counted in-memory inode table
// Lookup, claim and release of inode slots with disk address generation.
// ----------------------------------------------------------------------------
// One item is worked at a time. A get scans the slot RAM one slot per cycle
// through its single read port: a hit ends the scan at its slot, a miss reads
// every slot. The disk address is worked out by a registered multiply beside
// the scan; INODE_BYTES and DISK_BLOCK_BYTES must be powers of two. A put
// reads its slot and lowers its count if it is not zero; a put on a slot index
// beyond the table goes straight to the output. The result sits in an output
// register, so the next item is taken while it waits; that next result then
// waits inside the block, with the input closed, until the first is taken.
// The slot table needs no clearing pass after reset: per-slot valid flops
// make an unwritten slot read as free.
// ----------------------------------------------------------------------------
module inode_reference_table
  import irt_pkg::*;
#(
  parameter int TABLE_SLOTS      = TABLE_SLOTS_DEF,
  parameter int INODE_BYTES      = INODE_BYTES_DEF,
  parameter int DISK_BLOCK_BYTES = DISK_BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // inode_number, slot, links_zero, dirty
  input  logic              s_tuser,   // action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,   // slot_index, disk_block, block_offset,
                                       // write_back, release_inode, released_number
  output logic [STAT_W-1:0] m_tuser,   // status
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int MW = NUM_W + CNT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_PREAD  = 6'b001000,
    S_PCHECK = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] imap_count;
  logic [CFG_W-1:0] zmap_count;

  // input fields
  logic              in_action;
  logic [NUM_W-1:0]  in_number;
  logic [SLOT_W-1:0] in_slot;
  logic              in_links_zero;
  logic              in_dirty;
  logic              accept;
  logic              slot_ok;

  assign in_action     = s_tuser;
  assign in_number     = s_tdata[15:0];
  assign in_slot       = s_tdata[20:16];
  assign in_links_zero = s_tdata[21];
  assign in_dirty      = s_tdata[22];
  assign s_tready      = (state == S_IDLE);
  assign accept        = s_tvalid && s_tready;
  assign slot_ok       = (32'(in_slot) < 32'(TABLE_SLOTS));
  assign cfg_ready     = 1'b1;

  // held item
  logic [NUM_W-1:0]  item_number;
  logic [SLOT_W-1:0] item_slot;
  logic              item_links_zero;
  logic              item_dirty;

  // scan
  logic [SW-1:0]     ptr;
  logic              issuing;
  logic              chk_vld;
  logic [SW-1:0]     chk_idx;
  logic              hit;
  logic [SW-1:0]     hit_slot;
  logic [CNT_W-1:0]  hit_cnt;
  logic              have_free;
  logic [SW-1:0]     spare_slot;

  // result being built
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_wb;
  logic              res_rel;
  logic [NUM_W-1:0]  res_num;
  logic              use_loc;

  // slot RAM: {number, count}; valid flops mark entries ever written
  logic [TABLE_SLOTS-1:0] valid;
  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  logic [MW-1:0]     ram_wdata;
  logic [SW-1:0]     ram_raddr;
  logic [MW-1:0]     ram_rdata;
  logic              rd_v;
  logic [CNT_W-1:0]  rd_cnt;
  logic [NUM_W-1:0]  rd_num;

  irt_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = (state == S_SCAN) ? ptr : SW'(item_slot);
  assign rd_cnt    = rd_v ? ram_rdata[CNT_W-1:0] : '0;
  assign rd_num    = ram_rdata[CNT_W +: NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      valid <= '0;
    end else begin
      rd_v <= valid[ram_raddr];
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_slot;
    ram_wdata = {item_number, hit_cnt + 8'd1};
    if (state == S_UPDATE) begin
      if (hit) begin
        ram_we = (hit_cnt != CNT_MAX);
      end else if (have_free) begin
        ram_we    = 1'b1;
        ram_waddr = spare_slot;
        ram_wdata = {item_number, 8'd1};
      end
    end else if (state == S_PCHECK) begin
      ram_we    = (rd_cnt != '0);
      ram_waddr = SW'(item_slot);
      ram_wdata = {rd_num, rd_cnt - 8'd1};
    end
  end

  // address unit
  loc_res_t         loc;
  logic             loc_start;
  logic [NUM_W-1:0] loc_number;

  assign loc_start  = (accept && !in_action) || (state == S_PCHECK && rd_cnt != '0);
  assign loc_number = (state == S_IDLE) ? in_number : rd_num;

  irt_locate #(
    .INODE_BYTES      (INODE_BYTES),
    .DISK_BLOCK_BYTES (DISK_BLOCK_BYTES)
  ) u_locate (
    .clk    (clk),
    .rst    (rst),
    .start  (loc_start),
    .number (loc_number),
    .res    (loc)
  );

  logic out_load;
  logic [BLK_W-1:0] out_block;
  logic [OFF_W-1:0] out_offset;

  assign out_load   = (state == S_OUT) && (!m_tvalid || m_tready) && (!use_loc || loc.done);
  assign out_block  = use_loc ? (AREA_BASE + 16'(imap_count) + 16'(zmap_count) + loc.block_q)
                              : '0;
  assign out_offset = use_loc ? loc.offset : '0;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      imap_count <= 8'd1;
      zmap_count <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAP: imap_count <= cfg_data;
        REG_ZMAP: zmap_count <= cfg_data;
        default:  ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= (state == S_SCAN) && issuing;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!in_action) begin
              state   <= S_SCAN;
              issuing <= 1'b1;
            end else if (slot_ok) begin
              state <= S_PREAD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (chk_vld && ((rd_cnt != '0 && rd_num == item_number) ||
                          chk_idx == SW'(TABLE_SLOTS - 1))) begin
            state   <= S_UPDATE;
            issuing <= 1'b0;
          end else if (issuing && ptr == SW'(TABLE_SLOTS - 1)) begin
            issuing <= 1'b0;
          end
        end
        S_UPDATE: state <= S_OUT;
        S_PREAD:  state <= S_PCHECK;
        S_PCHECK: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    chk_idx <= ptr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          item_number     <= in_number;
          item_slot       <= in_slot;
          item_links_zero <= in_links_zero;
          item_dirty      <= in_dirty;
          ptr             <= '0;
          hit             <= 1'b0;
          have_free       <= 1'b0;
          res_wb          <= 1'b0;
          res_rel         <= 1'b0;
          res_slot        <= in_slot;
          if (!in_action) begin
            res_num <= in_number;
            use_loc <= 1'b1;
          end else begin
            res_status <= ST_UNUSED;
            res_num    <= '0;
            use_loc    <= 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (issuing) begin
          ptr <= ptr + SW'(1);
        end
        if (chk_vld) begin
          if (rd_cnt != '0) begin
            if (rd_num == item_number) begin
              hit      <= 1'b1;
              hit_slot <= chk_idx;
              hit_cnt  <= rd_cnt;
            end
          end else begin
            have_free  <= 1'b1;
            spare_slot <= chk_idx;
          end
        end
      end
      S_UPDATE: begin
        if (hit) begin
          res_slot   <= SLOT_W'(hit_slot);
          res_status <= (hit_cnt == CNT_MAX) ? ST_OVERFLOW : ST_HIT;
        end else if (have_free) begin
          res_slot   <= SLOT_W'(spare_slot);
          res_status <= ST_FETCH;
        end else begin
          res_slot   <= '0;
          res_status <= ST_FULL;
        end
      end
      S_PCHECK: begin
        if (rd_cnt == '0) begin
          res_status <= ST_UNUSED;
        end else begin
          res_status <= ST_HIT;
          res_num    <= rd_num;
          use_loc    <= 1'b1;
          // count one means this put takes it to zero
          res_wb     <= (rd_cnt == 8'd1) && (item_dirty || item_links_zero);
          res_rel    <= (rd_cnt == 8'd1) && item_links_zero;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {7'd0, res_num, res_rel, res_wb, out_offset, out_block, res_slot};
    end
  end

endmodule

FILE: sv/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker: port-level checks for the inode reference table
// Bound to the top level; watches the result channel.
// ----------------------------------------------------------------------------
module irt_checker
  import irt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [55:0]       m_tdata,
  input logic [STAT_W-1:0] m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_HIT || m_tuser == ST_FETCH || m_tuser == ST_FULL ||
                  m_tuser == ST_UNUSED || m_tuser == ST_OVERFLOW))
    else $error("status code out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_UNUSED |-> m_tdata[55:5] == '0)
    else $error("unused put carries address or number");

  a_wb_on_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[31] || m_tdata[32]) |-> m_tuser == ST_HIT)
    else $error("write-back or release on a non-done status");

  a_rel_implies_wb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[31])
    else $error("release without write-back");

endmodule

bind inode_reference_table irt_checker u_irt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for inode_reference_table
// Directed and random get/put traffic against a local model of the slot
// table and the inode address math; every result is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import irt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;
  localparam int   SETTLE_CYCLES = 48;
  localparam int   MAX_PRINTS = 40;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [BLK_W-1:0]  disk_block;
    logic [OFF_W-1:0]  block_offset;
    logic              write_back;
    logic              release_inode;
    logic [NUM_W-1:0]  released_number;
  } inode_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;   // inode_number, slot, links_zero, dirty
  logic              s_tuser = 1'b0; // action
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [55:0]       m_tdata;        // slot_index, disk_block, block_offset,
                                     // write_back, release_inode, released_number
  logic [STAT_W-1:0] m_tuser;        // status
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  inode_reference_table dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // local copy of the slot table and the map registers
  logic [NUM_W-1:0] slot_num [TABLE_SLOTS_DEF];
  logic [CNT_W-1:0] slot_cnt [TABLE_SLOTS_DEF];
  logic [CFG_W-1:0] imap_blocks = 8'd1;
  logic [CFG_W-1:0] zmap_blocks = 8'd1;

  inode_result_t pending_results [$];
  int            err_count = 0;
  int            hold_cycles = 0;
  rx_mode_t      rx_mode = RX_OPEN;
  logic [7:0]    rx_pat = 8'hb5;
  int            burst_left = 0;
  bit            no_gaps = 1'b0;
  logic [NUM_W-1:0] number_pool [40];

  initial begin
    for (int k = 0; k < TABLE_SLOTS_DEF; k++) begin
      slot_num[k] = '0;
      slot_cnt[k] = '0;
    end
  end

  function automatic void inode_location(input logic [NUM_W-1:0] num,
                                         output logic [BLK_W-1:0] blk,
                                         output logic [OFF_W-1:0] off);
    logic [NUM_W-1:0] idx;
    logic [31:0]      bytes;
    logic [31:0]      b;
    idx   = num - 16'd1;   // number zero wraps
    bytes = 32'(idx) * INODE_BYTES_DEF;
    b     = 32'(AREA_BASE) + 32'(imap_blocks) + 32'(zmap_blocks)
            + bytes / DISK_BLOCK_BYTES_DEF;
    blk   = b[BLK_W-1:0];
    off   = 10'(bytes % DISK_BLOCK_BYTES_DEF);
  endfunction

  // applies one request to the local table and returns its result
  function automatic inode_result_t table_step(input logic act,
                                               input logic [NUM_W-1:0] num,
                                               input logic [SLOT_W-1:0] sl,
                                               input logic lz, input logic dt);
    inode_result_t r;
    bit            hit;
    bit            have_free;
    int            hit_slot;
    int            spare_slot;
    r = '0;
    hit = 1'b0;
    have_free = 1'b0;
    hit_slot = 0;
    spare_slot = 0;
    if (act == ACT_GET) begin
      for (int k = 0; k < TABLE_SLOTS_DEF; k++) begin
        if (slot_cnt[k] != 0) begin
          if (!hit && slot_num[k] == num) begin
            hit = 1'b1;
            hit_slot = k;
          end
        end else if (!hit) begin
          have_free = 1'b1;
          spare_slot = k;   // last free one wins
        end
      end
      inode_location(num, r.disk_block, r.block_offset);
      r.released_number = num;
      if (hit) begin
        r.slot_index = SLOT_W'(hit_slot);
        if (slot_cnt[hit_slot] == CNT_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          slot_cnt[hit_slot] = slot_cnt[hit_slot] + 8'd1;
          r.status = ST_HIT;
        end
      end else if (have_free) begin
        slot_num[spare_slot] = num;
        slot_cnt[spare_slot] = 8'd1;
        r.slot_index = SLOT_W'(spare_slot);
        r.status = ST_FETCH;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      r.slot_index = sl;
      if (slot_cnt[sl] == 0) begin
        r.status = ST_UNUSED;
      end else begin
        slot_cnt[sl] = slot_cnt[sl] - 8'd1;
        inode_location(slot_num[sl], r.disk_block, r.block_offset);
        r.released_number = slot_num[sl];
        r.status = ST_HIT;
        if (slot_cnt[sl] == 0) begin
          r.write_back = dt | lz;
          r.release_inode = lz;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("tb: mismatch in %s: got %0h, want %0h (t=%0t)", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    inode_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", {8'h0, m_tdata[23:0]}, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status)
          report_mismatch("status", 32'(m_tuser), 32'(want.status));
        if (m_tdata[4:0] != want.slot_index)
          report_mismatch("slot_index", 32'(m_tdata[4:0]), 32'(want.slot_index));
        if (m_tdata[20:5] != want.disk_block)
          report_mismatch("disk_block", 32'(m_tdata[20:5]), 32'(want.disk_block));
        if (m_tdata[30:21] != want.block_offset)
          report_mismatch("block_offset", 32'(m_tdata[30:21]), 32'(want.block_offset));
        if (m_tdata[31] != want.write_back)
          report_mismatch("write_back", 32'(m_tdata[31]), 32'(want.write_back));
        if (m_tdata[32] != want.release_inode)
          report_mismatch("release_inode", 32'(m_tdata[32]), 32'(want.release_inode));
        if (m_tdata[48:33] != want.released_number)
          report_mismatch("released_number", 32'(m_tdata[48:33]),
                          32'(want.released_number));
        if (m_tdata[55:49] != 7'd0)
          report_mismatch("tdata padding", 32'(m_tdata[55:49]), 32'h0);
      end
    end
  end

  // receiver: stall pattern per mode, plus a long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        case (rx_mode)
          RX_OPEN:    m_tready <= 1'b1;
          RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: begin
            rx_pat = {rx_pat[6:0], rx_pat[7]};
            m_tready <= rx_pat[0];
          end
          default:    m_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send_item(input logic act, input logic [NUM_W-1:0] num,
                           input logic [SLOT_W-1:0] sl, input logic lz, input logic dt);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, dt, lz, sl, num};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(table_step(act, num, sl, lz, dt));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // sender in bursts with random gaps
  task automatic paced_send(input logic act, input logic [NUM_W-1:0] num,
                            input logic [SLOT_W-1:0] sl, input logic lz, input logic dt);
    if (!no_gaps && burst_left == 0) begin
      idle_cycles($urandom_range(1, 9));
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    send_item(act, num, sl, lz, dt);
  endtask

  // wait for every pending result, then let the block go quiet
  task automatic settle();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAP: imap_blocks = val;
      REG_ZMAP: zmap_blocks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_maps(input logic [CFG_W-1:0] imap, input logic [CFG_W-1:0] zmap);
    settle();
    write_reg(REG_IMAP, imap);
    write_reg(REG_ZMAP, zmap);
  endtask

  // drop every slot back to free
  task automatic clear_table();
    for (int s = 0; s < TABLE_SLOTS_DEF; s++)
      while (slot_cnt[s] != 0)
        paced_send(ACT_PUT, 16'($urandom), SLOT_W'(s), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_reset_defaults();
    rx_mode = RX_RANDOM;
    send_item(ACT_GET, 16'd1, 5'd0, 1'b0, 1'b0);       // claim
    send_item(ACT_GET, 16'd1, 5'd31, 1'b1, 1'b1);      // hit
    send_item(ACT_GET, 16'hffff, 5'd0, 1'b0, 1'b0);
    send_item(ACT_GET, 16'd0, 5'd0, 1'b0, 1'b0);       // wraps to top index
    send_item(ACT_GET, 16'd32, 5'd0, 1'b0, 1'b0);      // last inode of a block
    send_item(ACT_GET, 16'd33, 5'd0, 1'b0, 1'b0);      // first of the next
    send_item(ACT_PUT, 16'd0, 5'd31, 1'b0, 1'b0);      // still in use
    send_item(ACT_PUT, 16'd0, 5'd31, 1'b0, 1'b1);      // reaches zero, dirty
    send_item(ACT_PUT, 16'd0, 5'd31, 1'b0, 1'b0);      // now unused
    send_item(ACT_PUT, 16'hffff, 5'd30, 1'b1, 1'b0);   // zero links
    send_item(ACT_PUT, 16'd0, 5'd29, 1'b0, 1'b0);      // clean, no write-back
    send_item(ACT_PUT, 16'd0, 5'd0, 1'b1, 1'b1);       // never used
    send_item(ACT_GET, 16'hffff, 5'd0, 1'b0, 1'b0);
    send_item(ACT_PUT, 16'd0, 5'd28, 1'b1, 1'b1);
    send_item(ACT_PUT, 16'd0, 5'd27, 1'b0, 1'b0);
    send_item(ACT_GET, 16'h8000, 5'd0, 1'b0, 1'b0);
    send_item(ACT_GET, 16'h7fff, 5'd0, 1'b0, 1'b0);
    clear_table();
  endtask

  task automatic test_map_extremes();
    set_maps(8'd0, 8'd0);
    send_item(ACT_GET, 16'd1, 5'd0, 1'b0, 1'b0);
    send_item(ACT_GET, 16'hffff, 5'd0, 1'b0, 1'b0);
    send_item(ACT_GET, 16'd0, 5'd0, 1'b0, 1'b0);
    clear_table();
    set_maps(8'd255, 8'd255);
    send_item(ACT_GET, 16'd1, 5'd0, 1'b0, 1'b0);
    send_item(ACT_GET, 16'hffff, 5'd0, 1'b0, 1'b0);
    send_item(ACT_GET, 16'd0, 5'd0, 1'b0, 1'b0);
    clear_table();
    set_maps(8'd255, 8'd0);
  endtask

  task automatic test_table_full();
    rx_mode = RX_PATTERN;
    clear_table();
    // 32 claims, then the table refuses new numbers
    for (int n = 0; n < 40; n++)
      paced_send(ACT_GET, 16'(1000 + n), 5'($urandom), 1'($urandom), 1'($urandom));
    send_item(ACT_GET, 16'd1005, 5'd0, 1'b0, 1'b0);
    clear_table();
  endtask

  task automatic test_count_overflow();
    rx_mode = RX_OPEN;
    set_maps(8'd0, 8'd255);
    // one claim and 254 hits bring the count to its ceiling
    repeat (257) paced_send(ACT_GET, 16'd77, 5'd0, 1'b0, 1'b0);
    clear_table();
  endtask

  task automatic test_backpressure();
    rx_mode = RX_OPEN;
    settle();
    hold_cycles = 400;
    repeat (30) send_item(ACT_GET, 16'($urandom_range(1, 50)), 5'd0, 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [NUM_W-1:0]  num;
    logic [SLOT_W-1:0] sl;
    logic              act;
    int                used [$];
    int                r;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       set_maps(8'd1, 8'd1);
        1:       set_maps(8'd0, 8'd0);
        2:       set_maps(8'd255, 8'd255);
        default: set_maps(8'($urandom), 8'($urandom));
      endcase
      rx_mode = rx_mode_t'(phase == 0 ? RX_OPEN : $urandom_range(0, 3));
      rx_pat = 8'($urandom) | 8'h01;
      no_gaps = (phase == 0);
      for (int k = 0; k < 40; k++)
        number_pool[k] = 16'($urandom);
      repeat (110) begin
        r = $urandom_range(0, 99);
        act = (r < 55) ? ACT_GET : ACT_PUT;
        r = $urandom_range(0, 99);
        if (r < 75)      num = number_pool[$urandom_range(0, 39)];
        else if (r < 90) num = 16'($urandom);
        else begin
          case ($urandom_range(0, 4))
            0:       num = 16'd0;
            1:       num = 16'd1;
            2:       num = 16'hffff;
            3:       num = 16'h8000;
            default: num = 16'h7fff;
          endcase
        end
        sl = 5'($urandom);
        if (act == ACT_PUT && $urandom_range(0, 99) < 85) begin
          used.delete();
          for (int s = 0; s < TABLE_SLOTS_DEF; s++)
            if (slot_cnt[s] != 0) used.push_back(s);
          if (used.size() != 0) sl = SLOT_W'(used[$urandom_range(0, used.size() - 1)]);
        end
        paced_send(act, num, sl, 1'($urandom), 1'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_map_extremes();
    test_table_full();
    test_count_overflow();
    test_backpressure();
    test_random_traffic();
    settle();
    if (pending_results.size() != 0)
      report_mismatch("items never returned", pending_results.size(), 32'h0);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
